// ----- rtl/core/lzw_byte_compressor_defines.svh -----
// assertion macros shared by the lzw compressor rtl
// no dependencies
`ifndef LZW_BYTE_COMPRESSOR_DEFINES_SVH
`define LZW_BYTE_COMPRESSOR_DEFINES_SVH

// implication or plain property checked on every clock edge out of reset
`define LZW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never hold out of reset
`define LZW_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- rtl/core/lzw_pkg.sv -----
// shared types and constants of the lzw byte compressor
// no dependencies
package lzw_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } lzw_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_stream;
  } lzw_out_t;

  typedef struct packed {
    lzw_in_t raw;
    logic    first;
  } lzw_cmd_t;

  typedef struct packed {
    logic clearing;
  } lzw_stat_t;

  localparam int unsigned FIRST_CODE = 256;
  localparam int unsigned EP_W       = 4;
  localparam logic [7:0] LZW_HDR [4] = '{8'h4C, 8'h5A, 8'h57, 8'h31};

endpackage

// ----- rtl/core/lzw_byte_compressor.sv -----
// channel   | handshake    | payload
// input     | push_i/full_o | in_item_i  (data_byte, last_byte)
// result    | pop_i/empty_o | out_item_o (out_byte, end_of_run, end_of_stream)
// a hit passes S_RD and S_CMP, again for each extra probe, a miss the same plus S_PACK for its bytes;
// the first byte of a stream emits the four header bytes in S_HDR, the dictionary port sets the pace
// after reset, and again after every 15 streams, a clearing pass over all 2^(CODE_BITS+1)
// dictionary entries runs with full_o high
// depends on lzw_pkg, lzw_front, lzw_back, lzw_ofifo
module lzw_byte_compressor #(
  parameter int unsigned CODE_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  lzw_pkg::lzw_in_t  in_item_i,
  input  logic              pop_i,
  output logic              empty_o,
  output lzw_pkg::lzw_out_t out_item_o
);
  import lzw_pkg::*;

  lzw_stat_t stat;
  lzw_cmd_t  cmd;
  logic      cmd_valid, cmd_pop;
  logic      wr, wfull;
  lzw_out_t  wdata;

  lzw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_item_i  (in_item_i),
    .stat_i     (stat),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  lzw_back #(.CODE_BITS(CODE_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .stat_o     (stat),
    .wr_o       (wr),
    .wdata_o    (wdata),
    .wfull_i    (wfull)
  );

  lzw_ofifo u_ofifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .wdata_i   (wdata),
    .wfull_o   (wfull),
    .pop_i     (pop_i),
    .empty_o   (empty_o),
    .out_item_o(out_item_o)
  );

endmodule

// ----- rtl/core/lzw_front.sv -----
// front end: accepts input transactions, tags stream starts, two-entry queue
// depends on lzw_pkg
module lzw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  lzw_pkg::lzw_in_t  in_item_i,
  input  lzw_pkg::lzw_stat_t stat_i,
  output logic              cmd_valid_o,
  output lzw_pkg::lzw_cmd_t cmd_o,
  input  logic              cmd_pop_i
);
  import lzw_pkg::*;

  lzw_cmd_t   buf_q [2];
  logic       rd_q, rd_d, wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       open_q, open_d;
  logic       acc, pop;

  assign full_o      = (cnt_q == 2'd2) | stat_i.clearing;
  assign acc         = push_i & ~full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i & cmd_valid_o;
  assign cmd_o       = buf_q[rd_q];

  always_comb begin
    open_d = open_q;
    rd_d   = rd_q;
    wr_d   = wr_q;
    cnt_d  = cnt_q;
    if (acc) begin
      open_d = ~in_item_i.last_byte;
      wr_d   = ~wr_q;
    end
    if (pop) begin
      rd_d = ~rd_q;
    end
    if (acc && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !acc) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      buf_q[wr_q] <= '{raw: in_item_i, first: ~open_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rd_q   <= 1'b0;
      wr_q   <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      open_q <= open_d;
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/lzw_ofifo.sv -----
// result queue between the back end and the pop side, four entries
// depends on lzw_pkg
module lzw_ofifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  lzw_pkg::lzw_out_t wdata_i,
  output logic              wfull_o,
  input  logic              pop_i,
  output logic              empty_o,
  output lzw_pkg::lzw_out_t out_item_o
);
  import lzw_pkg::*;

  lzw_out_t   buf_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q, cnt_d;
  logic       wr, rd;

  assign wfull_o    = (cnt_q == 3'd4);
  assign empty_o    = (cnt_q == 3'd0);
  assign wr         = wr_i & ~wfull_o;
  assign rd         = pop_i & ~empty_o;
  assign out_item_o = buf_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + 3'd1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      buf_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 2'd0;
      wr_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) begin
        wr_q <= wr_q + 2'd1;
      end
      if (rd) begin
        rd_q <= rd_q + 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/lzw_back.sv -----
// back end: hashed dictionary with linear probing, code packer, header emitter
// depends on lzw_pkg and lzw_byte_compressor_defines.svh
`include "lzw_byte_compressor_defines.svh"
module lzw_back #(
  parameter int unsigned CODE_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  lzw_pkg::lzw_cmd_t  cmd_i,
  output logic               cmd_pop_o,
  output lzw_pkg::lzw_stat_t stat_o,
  output logic               wr_o,
  output lzw_pkg::lzw_out_t  wdata_o,
  input  logic               wfull_i
);
  import lzw_pkg::*;

  localparam int unsigned HB    = CODE_BITS + 1;
  localparam int unsigned KW    = CODE_BITS + 8;
  localparam int unsigned ENT_W = EP_W + KW + CODE_BITS;
  localparam int unsigned DEPTH = 1 << HB;
  localparam int unsigned ACC_W = CODE_BITS + 8;
  localparam int unsigned CNT_W = $clog2(ACC_W + 1);
  localparam int unsigned NW    = CODE_BITS + 1;
  localparam logic [NW-1:0]   CODE_LIMIT = {1'b1, {CODE_BITS{1'b0}}};
  localparam logic [EP_W-1:0] EP_MAX     = {EP_W{1'b1}};

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HDR  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_PACK = 3'd5;

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_q;

  logic [2:0]           state_q, state_d;
  lzw_in_t              item_q, item_d;
  logic [CODE_BITS-1:0] prefix_q, prefix_d;
  logic [NW-1:0]        nfc_q, nfc_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 fin_q, fin_d;
  logic [EP_W-1:0]      ep_q, ep_d;
  logic [HB-1:0]        probe_q, probe_d;
  logic [HB-1:0]        clr_q, clr_d;
  logic [1:0]           hidx_q, hidx_d;

  logic                 we;
  logic [HB-1:0]        wa;
  logic [ENT_W-1:0]     wd;
  logic [KW-1:0]        key;
  logic [EP_W-1:0]      r_ep;
  logic [KW-1:0]        r_key;
  logic [CODE_BITS-1:0] r_code;
  logic [ACC_W-1:0]     pack_acc;
  logic [CNT_W-1:0]     pack_cnt, rem;
  logic                 lastb;

  assign key      = {prefix_q, item_q.data_byte};
  assign r_ep     = rd_q[ENT_W-1 -: EP_W];
  assign r_key    = rd_q[CODE_BITS +: KW];
  assign r_code   = rd_q[CODE_BITS-1:0];
  assign pack_acc = acc_q | (ACC_W'(prefix_q) << cnt_q);
  assign pack_cnt = cnt_q + CNT_W'(CODE_BITS);
  assign rem      = cnt_q - CNT_W'(8);
  assign stat_o   = '{clearing: (state_q == S_CLR)};

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    prefix_d  = prefix_q;
    nfc_d     = nfc_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    fin_d     = fin_q;
    ep_d      = ep_q;
    probe_d   = probe_q;
    clr_d     = clr_q;
    hidx_d    = hidx_q;
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    wa        = probe_q;
    wd        = {ep_q, key, nfc_q[CODE_BITS-1:0]};
    wr_o      = 1'b0;
    wdata_o   = '{out_byte: acc_q[7:0], end_of_run: 1'b0, end_of_stream: 1'b0};
    lastb     = 1'b0;
    case (state_q)
      S_CLR: begin
        we    = 1'b1;
        wa    = clr_q;
        wd    = '0;
        clr_d = clr_q + HB'(1);
        if (clr_q == {HB{1'b1}}) begin
          ep_d    = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.first && ep_q == EP_MAX) begin
            clr_d   = '0;
            state_d = S_CLR;
          end else begin
            cmd_pop_o = 1'b1;
            item_d    = cmd_i.raw;
            if (cmd_i.first) begin
              prefix_d = CODE_BITS'(cmd_i.raw.data_byte);
              nfc_d    = NW'(FIRST_CODE);
              acc_d    = '0;
              cnt_d    = '0;
              ep_d     = ep_q + EP_W'(1);
              hidx_d   = 2'd0;
              fin_d    = cmd_i.raw.last_byte;
              state_d  = S_HDR;
            end else begin
              probe_d = HB'(prefix_q) ^ (HB'(cmd_i.raw.data_byte) << (HB - 8));
              state_d = S_RD;
            end
          end
        end
      end
      S_HDR: begin
        lastb   = (hidx_q == 2'd3) && !item_q.last_byte;
        wr_o    = 1'b1;
        wdata_o = '{out_byte: LZW_HDR[hidx_q], end_of_run: lastb, end_of_stream: 1'b0};
        if (!wfull_i) begin
          hidx_d = hidx_q + 2'd1;
          if (hidx_q == 2'd3) begin
            state_d = fin_q ? S_PACK : S_IDLE;
          end
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (r_ep != ep_q) begin
          if (nfc_q < CODE_LIMIT) begin
            we    = 1'b1;
            nfc_d = nfc_q + NW'(1);
          end
          acc_d    = pack_acc;
          cnt_d    = pack_cnt;
          prefix_d = CODE_BITS'(item_q.data_byte);
          fin_d    = item_q.last_byte;
          state_d  = S_PACK;
        end else if (r_key == key) begin
          prefix_d = r_code;
          fin_d    = item_q.last_byte;
          state_d  = item_q.last_byte ? S_PACK : S_IDLE;
        end else begin
          probe_d = probe_q + HB'(1);
          state_d = S_RD;
        end
      end
      S_PACK: begin
        if (cnt_q >= CNT_W'(8)) begin
          lastb = (rem < CNT_W'(8)) && !fin_q && !(item_q.last_byte && rem != '0);
          wr_o  = 1'b1;
          wdata_o = '{out_byte: acc_q[7:0], end_of_run: lastb,
                      end_of_stream: lastb & item_q.last_byte};
          if (!wfull_i) begin
            acc_d = acc_q >> 8;
            cnt_d = rem;
            if (lastb) begin
              state_d = S_IDLE;
            end
          end
        end else if (fin_q) begin
          acc_d = pack_acc;
          cnt_d = pack_cnt;
          fin_d = 1'b0;
        end else if (item_q.last_byte && cnt_q != '0) begin
          wr_o    = 1'b1;
          wdata_o = '{out_byte: acc_q[7:0], end_of_run: 1'b1, end_of_stream: 1'b1};
          if (!wfull_i) begin
            acc_d   = '0;
            cnt_d   = '0;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[probe_q];
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    probe_q <= probe_d;
    hidx_q  <= hidx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      prefix_q <= '0;
      nfc_q    <= NW'(FIRST_CODE);
      acc_q    <= '0;
      cnt_q    <= '0;
      fin_q    <= 1'b0;
      ep_q     <= '0;
      clr_q    <= '0;
    end else begin
      state_q  <= state_d;
      prefix_q <= prefix_d;
      nfc_q    <= nfc_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      fin_q    <= fin_d;
      ep_q     <= ep_d;
      clr_q    <= clr_d;
    end
  end

  `LZW_ASSERT(a_idle_partial, clk_i, rst_ni, (state_q == S_IDLE) |-> (cnt_q < CNT_W'(8)), "packer left a whole byte")
  `LZW_ASSERT(a_nfc_range, clk_i, rst_ni, nfc_q <= CODE_LIMIT, "next free code beyond limit")
  `LZW_NEVER(a_insert_frozen, clk_i, rst_ni, we && (state_q == S_CMP) && (nfc_q >= CODE_LIMIT), "insert into frozen dictionary")
  `LZW_ASSERT(a_lookup_epoch, clk_i, rst_ni, (state_q == S_RD) |-> (ep_q != '0), "lookup without open stream")

endmodule
